// File: design/mpmm_pkg.sv
// Shared constants, payload types and helper functions of the message mailbox.
package mpmm_pkg;

  localparam int NUM_PORTS   = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_PAYLOAD = 32;

  localparam int SLOT_COUNT = NUM_PORTS * QUEUE_DEPTH;
  localparam int BYTE_COUNT = SLOT_COUNT * MAX_PAYLOAD;

  localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ADDR_W = (BYTE_COUNT > 1) ? $clog2(BYTE_COUNT) : 1;
  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int ALEN_W = $clog2(MAX_PAYLOAD + 2);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERR   = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic       req_type;
    logic [3:0] port;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] capacity;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic       from_receive;
    logic [7:0] out_byte;
    logic [6:0] message_length;
    logic       final_of_run;
    logic [2:0] pending_count;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic issue_read;
    logic load_byte;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rsp_valid;
    logic stream_start;
    logic more;
  } dp_status_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [PIDX_W-1:0] pi,
                                                input logic [PTR_W-1:0] ptr);
    return SLOT_W'(int'(pi) * QUEUE_DEPTH + int'(ptr));
  endfunction

  function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] slot);
    return ADDR_W'(int'(slot) * MAX_PAYLOAD);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(ptr + 1'b1);
  endfunction

  function automatic logic [2:0] pend3(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+2:0] w;
    w = {3'b000, cnt};
    return w[2:0];
  endfunction

endpackage

// File: design/multi_port_message_mailbox.sv
// Top level of the multi-port message mailbox: sequencer joined to datapath.
//
// Each of NUM_PORTS ports keeps a ring of QUEUE_DEPTH messages of up to
// MAX_PAYLOAD bytes. A send request carries one byte; the request holding the
// last byte of a message yields one response (committed or rejected), earlier
// bytes yield none. A receive request that finds a fitting message streams it
// out one byte per response and pops it: it occupies the block until every
// byte has passed the registered read port of the byte store into the
// response register, and bytes follow one per cycle while the response side
// keeps up. A receive that fails (zero capacity, bad or empty port, message
// too long) answers with one response.
// A new request is taken while the previous response is still waiting only if
// that response leaves in the same cycle. The stores need no clearing after
// reset; the per-port pointers and counts, the assembly and stream state and
// the response valid flag are reset.
module multi_port_message_mailbox (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  mpmm_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output mpmm_pkg::rsp_t  rsp
);

  mpmm_pkg::ctrl_cmd_t  cmd;
  mpmm_pkg::dp_status_t sts;

  // sequencer: decide acceptance, issue byte reads, load the response register
  mpmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: hold the queues, assemble messages and drive the response
  mpmm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .rsp       (rsp)
  );

  assign rsp_valid = sts.rsp_valid;

endmodule

// File: design/mpmm_ctrl.sv
// Sequencer of the message mailbox: request acceptance and byte streaming.
module mpmm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic                rsp_ready,
  input  mpmm_pkg::dp_status_t sts,
  output mpmm_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_t;

  state_t state, state_next;
  logic   pending, pending_next;
  logic   out_free;

  always_comb begin
    out_free       = !sts.rsp_valid || rsp_ready;
    req_ready      = (state == S_IDLE) && out_free;
    cmd.accept     = req_valid && req_ready;
    cmd.load_byte  = pending && out_free;
    cmd.issue_read = (state == S_STREAM) && sts.more && (!pending || cmd.load_byte);
    pending_next   = cmd.issue_read || (pending && !cmd.load_byte);
    state_next     = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept && sts.stream_start) state_next = S_STREAM;
      end
      S_STREAM: begin
        if (!sts.more && !pending_next) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

endmodule

// File: design/mpmm_datapath.sv
// Queues, byte store, message assembly and response register of the mailbox.
module mpmm_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  mpmm_pkg::req_t       req,
  input  mpmm_pkg::ctrl_cmd_t  cmd,
  input  logic                 rsp_ready,
  output mpmm_pkg::dp_status_t sts,
  output mpmm_pkg::rsp_t       rsp
);

  // byte store and committed lengths
  logic [7:0]                     mem [mpmm_pkg::BYTE_COUNT];
  logic [7:0]                     rd_data;
  logic [mpmm_pkg::LEN_W-1:0]     slot_len [mpmm_pkg::SLOT_COUNT];

  // per-port ring state
  logic [mpmm_pkg::PTR_W-1:0]     rdp    [mpmm_pkg::NUM_PORTS];
  logic [mpmm_pkg::PTR_W-1:0]     wrp    [mpmm_pkg::NUM_PORTS];
  logic [mpmm_pkg::CNT_W-1:0]     queued [mpmm_pkg::NUM_PORTS];

  // message under assembly
  logic [mpmm_pkg::ALEN_W-1:0]    alen;
  logic [3:0]                     aport;
  logic                           ablocked;

  // stream in progress
  logic [mpmm_pkg::ADDR_W-1:0]    str_base;
  logic [mpmm_pkg::LEN_W-1:0]     str_len;
  logic [mpmm_pkg::LEN_W-1:0]     str_idx;
  logic [2:0]                     str_pend;
  logic                           rd_last;

  logic                           rsp_valid;

  // send side
  logic                           s_first, s_valid, s_full, s_store_ok, s_blk, s_bad;
  logic [3:0]                     s_port;
  logic [mpmm_pkg::PIDX_W-1:0]    s_pi;
  logic [mpmm_pkg::CNT_W-1:0]     s_q;
  logic [mpmm_pkg::SLOT_W-1:0]    s_slot;
  logic [mpmm_pkg::ALEN_W-1:0]    s_len_inc;
  logic                           is_send, mem_we;
  logic [mpmm_pkg::ADDR_W-1:0]    wr_addr, rd_addr;

  // receive side
  logic                           r_valid, r_cap0, r_empty, r_toolong, r_start;
  logic [mpmm_pkg::PIDX_W-1:0]    r_pi;
  logic [mpmm_pkg::CNT_W-1:0]     r_q;
  logic [mpmm_pkg::SLOT_W-1:0]    r_slot;
  logic [mpmm_pkg::LEN_W-1:0]     r_len;
  logic                           is_recv;

  always_comb begin
    s_first    = (alen == '0);
    s_port     = s_first ? req.port : aport;
    s_valid    = ({1'b0, s_port} < 5'(mpmm_pkg::NUM_PORTS));
    s_pi       = s_valid ? s_port[mpmm_pkg::PIDX_W-1:0] : '0;
    s_q        = queued[s_pi];
    s_full     = (s_q >= mpmm_pkg::CNT_W'(mpmm_pkg::QUEUE_DEPTH));
    s_store_ok = s_valid && !s_full;
    s_blk      = (!s_first && ablocked) || !s_store_ok;
    s_slot     = mpmm_pkg::slot_of(s_pi, wrp[s_pi]);
    s_len_inc  = (alen <= mpmm_pkg::ALEN_W'(mpmm_pkg::MAX_PAYLOAD)) ?
                 mpmm_pkg::ALEN_W'(alen + 1'b1) : alen;
    s_bad      = s_blk || (s_len_inc > mpmm_pkg::ALEN_W'(mpmm_pkg::MAX_PAYLOAD));
    is_send    = cmd.accept && !req.req_type;
    mem_we     = is_send && s_store_ok && (alen < mpmm_pkg::ALEN_W'(mpmm_pkg::MAX_PAYLOAD));
    wr_addr    = mpmm_pkg::ADDR_W'(mpmm_pkg::slot_base(s_slot) + mpmm_pkg::ADDR_W'(alen));

    r_valid    = ({1'b0, req.port} < 5'(mpmm_pkg::NUM_PORTS));
    r_pi       = r_valid ? req.port[mpmm_pkg::PIDX_W-1:0] : '0;
    r_q        = queued[r_pi];
    r_slot     = mpmm_pkg::slot_of(r_pi, rdp[r_pi]);
    r_len      = slot_len[r_slot];
    r_cap0     = (req.capacity == 8'd0);
    r_empty    = !r_valid || (r_q == '0);
    r_toolong  = (8'(r_len) > req.capacity);
    r_start    = req.req_type && !r_cap0 && !r_empty && !r_toolong;
    is_recv    = cmd.accept && req.req_type;

    rd_addr    = mpmm_pkg::ADDR_W'(str_base + mpmm_pkg::ADDR_W'(str_idx));

    sts.rsp_valid    = rsp_valid;
    sts.stream_start = r_start;
    sts.more         = (str_idx < str_len);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= req.data_byte;
    if (cmd.issue_read) rd_data <= mem[rd_addr];
  end

  // queue and assembly state
  always_ff @(posedge clk) begin
    if (rst) begin
      alen     <= '0;
      aport    <= '0;
      ablocked <= 1'b0;
      for (int i = 0; i < mpmm_pkg::NUM_PORTS; i++) begin
        rdp[i]    <= '0;
        wrp[i]    <= '0;
        queued[i] <= '0;
      end
    end else if (is_send) begin
      if (req.last_byte) begin
        alen     <= '0;
        ablocked <= 1'b0;
        if (!s_bad) begin
          wrp[s_pi]    <= mpmm_pkg::ptr_inc(wrp[s_pi]);
          queued[s_pi] <= mpmm_pkg::CNT_W'(s_q + 1'b1);
        end
      end else begin
        alen     <= s_len_inc;
        aport    <= s_port;
        ablocked <= s_blk;
      end
    end else if (is_recv && r_start) begin
      rdp[r_pi]    <= mpmm_pkg::ptr_inc(rdp[r_pi]);
      queued[r_pi] <= mpmm_pkg::CNT_W'(r_q - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (is_send && req.last_byte && !s_bad) slot_len[s_slot] <= mpmm_pkg::LEN_W'(s_len_inc);
  end

  // stream bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      str_idx <= '0;
      str_len <= '0;
    end else if (is_recv && r_start) begin
      str_idx <= '0;
      str_len <= r_len;
    end else if (cmd.issue_read) begin
      str_idx <= mpmm_pkg::LEN_W'(str_idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (is_recv && r_start) begin
      str_base <= mpmm_pkg::slot_base(r_slot);
      str_pend <= mpmm_pkg::pend3(mpmm_pkg::CNT_W'(r_q - 1'b1));
    end
    if (cmd.issue_read) rd_last <= (mpmm_pkg::LEN_W'(str_idx + 1'b1) == str_len);
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((is_send && req.last_byte) || (is_recv && !r_start) || cmd.load_byte) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_send && req.last_byte) begin
      rsp.status         <= s_bad ? mpmm_pkg::ST_ERR : mpmm_pkg::ST_OK;
      rsp.from_receive   <= 1'b0;
      rsp.out_byte       <= 8'd0;
      rsp.message_length <= s_bad ? 7'd0 : 7'(s_len_inc);
      rsp.final_of_run   <= 1'b1;
      if (!s_valid)    rsp.pending_count <= 3'd0;
      else if (s_bad)  rsp.pending_count <= mpmm_pkg::pend3(s_q);
      else             rsp.pending_count <= mpmm_pkg::pend3(mpmm_pkg::CNT_W'(s_q + 1'b1));
    end else if (is_recv && !r_start) begin
      rsp.status         <= (!r_cap0 && r_empty) ? mpmm_pkg::ST_EMPTY : mpmm_pkg::ST_ERR;
      rsp.from_receive   <= 1'b1;
      rsp.out_byte       <= 8'd0;
      rsp.message_length <= 7'd0;
      rsp.final_of_run   <= 1'b1;
      rsp.pending_count  <= r_valid ? mpmm_pkg::pend3(r_q) : 3'd0;
    end else if (cmd.load_byte) begin
      rsp.status         <= mpmm_pkg::ST_OK;
      rsp.from_receive   <= 1'b1;
      rsp.out_byte       <= rd_data;
      rsp.message_length <= 7'(str_len);
      rsp.final_of_run   <= rd_last;
      rsp.pending_count  <= str_pend;
    end
  end

endmodule
